@@ rtl/gdc_pkg.sv @@
// ----------------------------------------------------------------------------
// gdc_pkg
// Shared types, constants and the month length table for the date counter.
// ----------------------------------------------------------------------------
package gdc_pkg;

  localparam int DAY_W   = 5;
  localparam int MONTH_W = 4;
  localparam int YEAR_W  = 12;
  localparam int DOY_W   = 9;
  localparam int YM400_W = 9;
  localparam int COUNT_W = 16;

  localparam int IN_DATA_W  = 40;
  localparam int OUT_DATA_W = 32;

  localparam logic [YEAR_W-1:0]  YEAR_MIN = 12'd1900;
  localparam logic [YEAR_W-1:0]  YEAR_MAX = 12'd2100;
  localparam logic [YEAR_W-1:0]  YEAR_SAT = 12'd4095;
  localparam logic [YEAR_W-1:0]  YEAR_400_BASE = 12'd1600;
  localparam logic [YM400_W-1:0] YM400_RESET = 9'd300;    // 1900 mod 400
  localparam logic [YM400_W-1:0] YM400_LAST  = 9'd399;
  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;
  localparam logic [DAY_W-1:0]   DAY_FIRST = 5'd1;
  localparam logic [DAY_W-1:0]   DAY_LAST_DEC = 5'd31;
  localparam logic [DAY_W-1:0]   FEB_LEAP_LEN = 5'd29;

  localparam logic [DAY_W-1:0] MONTH_LEN [0:12] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31
  };

  typedef struct packed {
    logic [MONTH_W-1:0] month;
    logic [YM400_W-1:0] ym400;   // year mod 400
    logic [DOY_W-1:0]   acc;
  } cal_req_t;

  typedef struct packed {
    logic [DAY_W-1:0] mlen;
    logic             leap;
    logic [DOY_W-1:0] sum;     // acc plus month length
  } cal_rsp_t;

  function automatic logic is_leap(input logic [YM400_W-1:0] ym);
    logic div100;
    div100 = (ym == 9'd0) || (ym == 9'd100) || (ym == 9'd200) || (ym == 9'd300);
    return (ym == 9'd0) || ((ym[1:0] == 2'd0) && !div100);
  endfunction

  function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
    logic [DAY_W-1:0] len;
    case (m)
      4'd1, 4'd2, 4'd3, 4'd4, 4'd5, 4'd6,
      4'd7, 4'd8, 4'd9, 4'd10, 4'd11, 4'd12: len = MONTH_LEN[m];
      default:                                len = 5'd31;
    endcase
    if (m == MONTH_FEB && leap) begin
      len = FEB_LEAP_LEN;
    end
    return len;
  endfunction

endpackage

@@ rtl/gdc_cal_unit.sv @@
// ----------------------------------------------------------------------------
// gdc_cal_unit
// Shared calendar unit: leap test, month length and ordinal accumulate.
// ----------------------------------------------------------------------------
module gdc_cal_unit
  import gdc_pkg::*;
(
  input  cal_req_t req,
  output cal_rsp_t rsp
);

  logic             leap;
  logic [DAY_W-1:0] mlen;

  assign leap = is_leap(req.ym400);
  assign mlen = month_days(req.month, leap);

  assign rsp.leap = leap;
  assign rsp.mlen = mlen;
  assign rsp.sum  = req.acc + {{(DOY_W-DAY_W){1'b0}}, mlen};

endmodule

@@ rtl/gregorian_date_counter.sv @@
// ----------------------------------------------------------------------------
// gregorian_date_counter
// Gregorian date register with validated load and day-by-day advance.
//
//   channel  dir  fields (low bit first)
//   s_axis   in   tuser: func; tdata: new_day, new_month, new_year, advance_days
//   m_axis   out  tdata: cur_day, cur_month, cur_year, day_of_year
//
// A load stores the validated date and an advance steps n days, n being the
// days actually stepped; then the ordinal month sum runs. The day step and
// the month sum both run one cycle per step through the shared calendar unit.
// The block takes one request at a time; a new one is accepted while the
// last result still waits on m_axis. Reset (rst, synchronous) sets 1 Jan 1900.
// ----------------------------------------------------------------------------
module gregorian_date_counter
  import gdc_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [4:0] new_day, [8:5] new_month, [20:9] new_year, [36:21] advance_days
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  // [0] func
  input  logic                  s_axis_tuser,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [4:0] cur_day, [8:5] cur_month, [20:9] cur_year, [29:21] day_of_year
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_LOAD = 3'd1;
  localparam logic [2:0] ST_STEP = 3'd2;
  localparam logic [2:0] ST_ORD  = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]         state;
  logic [DAY_W-1:0]   day;
  logic [MONTH_W-1:0] month;
  logic [YEAR_W-1:0]  year;
  logic [YM400_W-1:0] ym400;
  logic [COUNT_W-1:0] cnt;
  logic [DOY_W-1:0]   acc;
  logic [MONTH_W-1:0] midx;

  logic [DAY_W-1:0]   in_day;
  logic [MONTH_W-1:0] in_month;
  logic [YEAR_W-1:0]  in_year;

  logic               accept;
  logic               out_free;
  logic               sat;
  logic [MONTH_W-1:0] ld_month;
  logic [YEAR_W-1:0]  ld_year;
  logic [YEAR_W-1:0]  ld_off;
  logic [YM400_W-1:0] ld_ym400;
  logic [DAY_W-1:0]   ld_day;

  cal_req_t req;
  cal_rsp_t rsp;

  assign s_axis_tready = (state == ST_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_axis_tvalid || m_axis_tready;
  assign sat           = (year == YEAR_SAT) && (month == MONTH_DEC) && (day == DAY_LAST_DEC);

  // validate the loaded date
  always_comb begin
    ld_month = (in_month inside {[4'd1:4'd12]}) ? in_month : MONTH_JAN;
    ld_year  = (in_year inside {[YEAR_MIN:YEAR_MAX]}) ? in_year : YEAR_MIN;
    ld_off   = ld_year - YEAR_400_BASE;
    ld_ym400 = (ld_off >= 12'd400) ? ld_off[YM400_W-1:0] - 9'd400 : ld_off[YM400_W-1:0];
    ld_day   = ((in_day != 5'd0) && (in_day <= rsp.mlen)) ? in_day : DAY_FIRST;
  end

  always_comb begin
    req.acc = acc;
    case (state)
      ST_LOAD: begin
        req.month = ld_month;
        req.ym400 = ld_ym400;
      end
      ST_ORD: begin
        req.month = midx;
        req.ym400 = ym400;
      end
      default: begin
        req.month = month;
        req.ym400 = ym400;
      end
    endcase
  end

  gdc_cal_unit u_cal (
    .req (req),
    .rsp (rsp)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      day           <= DAY_FIRST;
      month         <= MONTH_JAN;
      year          <= YEAR_MIN;
      ym400         <= YM400_RESET;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == ST_FIN && out_free) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (accept) begin
            cnt   <= s_axis_tdata[36:21];
            state <= s_axis_tuser ? ST_STEP : ST_LOAD;
          end
        end
        ST_LOAD: begin
          day   <= ld_day;
          month <= ld_month;
          year  <= ld_year;
          ym400 <= ld_ym400;
          acc   <= {{(DOY_W-DAY_W){1'b0}}, ld_day};
          midx  <= MONTH_JAN;
          state <= ST_ORD;
        end
        ST_STEP: begin
          if ((cnt == '0) || sat) begin
            // drop any remaining days once saturated
            acc   <= {{(DOY_W-DAY_W){1'b0}}, day};
            midx  <= MONTH_JAN;
            state <= ST_ORD;
          end else begin
            cnt <= cnt - 1'b1;
            if (day < rsp.mlen) begin
              day <= day + 1'b1;
            end else if (month < MONTH_DEC) begin
              month <= month + 1'b1;
              day   <= DAY_FIRST;
            end else begin
              month <= MONTH_JAN;
              day   <= DAY_FIRST;
              year  <= year + 1'b1;
              ym400 <= (ym400 == YM400_LAST) ? '0 : ym400 + 1'b1;
            end
          end
        end
        ST_ORD: begin
          if (midx < month) begin
            acc  <= rsp.sum;
            midx <= midx + 1'b1;
          end else begin
            state <= ST_FIN;
          end
        end
        ST_FIN: begin
          // hold until the output register is free
          if (out_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      in_day   <= s_axis_tdata[4:0];
      in_month <= s_axis_tdata[8:5];
      in_year  <= s_axis_tdata[20:9];
    end
    if (state == ST_FIN && out_free) begin
      m_axis_tdata <= {2'b00, acc, year, month, day};
    end
  end

  a_date_valid: assert property (@(posedge clk) disable iff (rst)
    (day != 5'd0) && (month >= MONTH_JAN) && (month <= MONTH_DEC) && (year >= YEAR_MIN))
    else $error("date register out of range");

  a_step_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_STEP) && (cnt != '0) && !sat |=> (cnt == $past(cnt) - 1'b1))
    else $error("day counter did not advance");

  a_ord_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_ORD) |-> (midx <= month))
    else $error("ordinal month index past current month");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> (state != ST_IDLE))
    else $error("accepted request not started");

endmodule
